>>> design/assert_macros.svh
// Assertion macros for the top level of the set design.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

>>> design/bisc_pkg.sv
// Package for the bounded ID set: sizes, status codes and transfer structs.
// Used by the cell and the top level; depends on nothing.
package bisc_pkg;

	localparam int MAX_SEATS = 32;
	localparam int ID_BITS = 16;
	localparam int CNT_W = $clog2(MAX_SEATS + 1);
	localparam int IDX_W = (MAX_SEATS > 1) ? $clog2(MAX_SEATS) : 1;

	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_DUPLICATE = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_REMOVED = 3'd3;
	localparam logic [2:0] ST_ABSENT = 3'd4;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	typedef struct packed {
		logic req_type;
		logic [ID_BITS-1:0] member_id;
	} bisc_req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [4:0] found_position;
		logic found_flag;
		logic [5:0] occupancy;
		logic [5:0] vacancies;
	} bisc_rsp_t;

	typedef struct packed {
		logic capture;
		logic valid;
		logic next_valid;
		logic load_new;
		logic shift_en;
	} bisc_cell_ctrl_t;

endpackage

>>> design/bisc_cell.sv
// One seat of the ID set: holds one entry, compares it with a request and
// shifts in its right neighbor's entry on removal. Depends on bisc_pkg.
module bisc_cell (
	input logic clk,
	input bisc_pkg::bisc_cell_ctrl_t ctrl,
	input logic [bisc_pkg::ID_BITS-1:0] req_id,
	input logic [bisc_pkg::ID_BITS-1:0] next_entry,
	input logic hit_in,
	output logic [bisc_pkg::ID_BITS-1:0] entry,
	output logic match,
	output logic hit_out
);
	import bisc_pkg::*;

	logic [ID_BITS-1:0] entry_q;
	logic match_q;

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			match_q <= ctrl.valid && (entry_q == req_id);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_new) begin
			entry_q <= req_id;
		end else if (ctrl.shift_en && hit_out && ctrl.next_valid) begin
			entry_q <= next_entry;
		end
	end

	assign hit_out = hit_in | match_q;
	assign match = match_q;
	assign entry = entry_q;

endmodule

>>> design/bounded_id_set_with_capacity_unit.sv
// Top level of the bounded ID set: a row of seat cells with the request
// sequencer, count and seat limit. Depends on bisc_pkg and bisc_cell.
//
// Usage: a request transfer takes place at a rising edge with start high and
// busy low; req carries the request kind and the member ID. In that edge every
// seat cell compares its entry with the ID at once. In the next cycle busy is
// high while the cells append the ID at the tail or shift later entries down
// to close the gap, and the count is updated. The result is on rsp with done
// high for exactly one cycle, registered from the update cycle through done_q;
// the receiver cannot stall it. A new request is accepted while that result
// is shown; each request goes through the compare step and then the update
// step of the cell row.
// The seat limit is written through cfg_we and cfg_wdata; the user must do so
// while no request is in progress; the block does not enforce it. Reset clears
// the count, sets the seat limit to 20 and drops busy and done; stored entries
// are not cleared, since only entries below the count are ever compared.
module bounded_id_set_with_capacity_unit (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input bisc_pkg::bisc_req_t req,
	input logic cfg_we,
	input logic [5:0] cfg_wdata,
	output logic done,
	output bisc_pkg::bisc_rsp_t rsp
);
	import bisc_pkg::*;

	`include "assert_macros.svh"

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_UPD = 2'b10
	} bisc_state_t;

	bisc_state_t state_q;
	bisc_req_t req_q;
	logic [CNT_W-1:0] count_q;
	logic [5:0] limit_q;
	logic done_q;
	bisc_rsp_t rsp_q;

	logic accept;
	logic upd;
	logic [ID_BITS-1:0] entries [MAX_SEATS];
	logic [MAX_SEATS-1:0] match_vec;
	logic [MAX_SEATS:0] hit_chain;
	bisc_cell_ctrl_t ctrl [MAX_SEATS];
	logic hit;
	logic [IDX_W-1:0] pos;
	logic [CNT_W-1:0] eff_limit;
	logic ins_go;
	logic rem_go;
	logic [CNT_W-1:0] count_next;
	logic [2:0] status_next;

	assign accept = start && (state_q == S_IDLE);
	assign upd = (state_q == S_UPD);
	assign busy = upd;
	assign hit = hit_chain[MAX_SEATS];
	assign hit_chain[0] = 1'b0;

	assign eff_limit = (int'(limit_q) >= MAX_SEATS) ? CNT_W'(MAX_SEATS) : CNT_W'(limit_q);
	assign ins_go = upd && (req_q.req_type == REQ_INSERT) && !hit && (count_q < eff_limit);
	assign rem_go = upd && (req_q.req_type == REQ_REMOVE) && hit;

	for (genvar i = 0; i < MAX_SEATS; i++) begin : g_cell
		logic [ID_BITS-1:0] nxt;

		if (i == MAX_SEATS - 1) begin : g_last
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = entries[i+1];
		end

		assign ctrl[i].capture = accept;
		assign ctrl[i].valid = (CNT_W'(i) < count_q);
		assign ctrl[i].next_valid = ((i + 1) < int'(count_q));
		assign ctrl[i].load_new = ins_go && (CNT_W'(i) == count_q);
		assign ctrl[i].shift_en = rem_go;

		bisc_cell u_cell (
			.clk(clk),
			.ctrl(ctrl[i]),
			.req_id(accept ? req.member_id : req_q.member_id),
			.next_entry(nxt),
			.hit_in(hit_chain[i]),
			.entry(entries[i]),
			.match(match_vec[i]),
			.hit_out(hit_chain[i+1])
		);
	end

	always_comb begin
		pos = '0;
		for (int i = 0; i < MAX_SEATS; i++) begin
			if (match_vec[i]) begin
				pos = pos | IDX_W'(i);
			end
		end
	end

	always_comb begin
		count_next = count_q;
		if (req_q.req_type == REQ_INSERT) begin
			if (hit) begin
				status_next = ST_DUPLICATE;
			end else if (count_q >= eff_limit) begin
				status_next = ST_FULL;
			end else begin
				status_next = ST_INSERTED;
				count_next = count_q + CNT_W'(1);
			end
		end else begin
			if (hit) begin
				status_next = ST_REMOVED;
				count_next = count_q - CNT_W'(1);
			end else begin
				status_next = ST_ABSENT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			limit_q <= 6'd20;
			done_q <= 1'b0;
		end else begin
			done_q <= upd;
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					state_q <= S_IDLE;
					count_q <= count_next;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (upd) begin
			rsp_q.status <= status_next;
			rsp_q.found_position <= 5'(pos);
			rsp_q.found_flag <= hit;
			rsp_q.occupancy <= 6'(count_next);
			rsp_q.vacancies <= (eff_limit > count_next) ? 6'(eff_limit - count_next) : 6'd0;
		end
	end

	assign done = done_q;
	assign rsp = rsp_q;

	`ASSERT_NEXT(a_result_follows_update, busy, done)
	`ASSERT_NEXT(a_no_result_without_update, !busy, !done)
	`ASSERT_SAME(a_single_match, busy, $onehot0(match_vec))
	`ASSERT_ALWAYS(a_count_in_range, count_q <= CNT_W'(MAX_SEATS))

endmodule
